>>> rtl/mtf_pkg.sv
// package for the move-to-front list: sizes, widths and the
// command/status structs between controller and datapath; no dependencies
package mtf_pkg;

  localparam int unsigned LIST_SIZE = 16;
  localparam int unsigned IDX_W     = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int unsigned VAL_W     = $clog2(LIST_SIZE + 1);
  localparam int unsigned QUERY_W   = 8;
  localparam int unsigned ENTRY_W   = 5;
  localparam int unsigned POS_W     = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] val_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture query, clear counter and hit flag
    logic find_step;  // compare one entry per cycle
    logic emit_step;  // rewrite one entry and emit it
  } mtf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;   // counter is on the final entry
  } mtf_stat_t;

endpackage

>>> rtl/move_to_front_list.sv
// move-to-front list of LIST_SIZE values, reset order 1..LIST_SIZE
// results: the first follows the find scan over all entries, then one per cycle
// a new query is accepted only once both the find scan and the emit/rewrite
// scan over the order registers are done, each scanning one entry a cycle
// results are strobed for one cycle each; the receiver cannot stall
// reset is asynchronous, active low, and restores the order at once
module move_to_front_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [mtf_pkg::QUERY_W-1:0]   query_value_i,
  output logic                          busy,
  output logic                          result_valid_o,
  output logic [mtf_pkg::ENTRY_W-1:0]   entry_value_o,
  output logic [mtf_pkg::POS_W-1:0]     position_o,
  output logic                          found_o,
  output logic                          last_o
);
  import mtf_pkg::*;

  mtf_cmd_t  cmd;
  mtf_stat_t stat;

  // sequencer: idle, find pass, emit pass
  mtf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // order registers, hit capture and result registers
  mtf_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .query_value_i  (query_value_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .entry_value_o  (entry_value_o),
    .position_o     (position_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

  // a result transaction only ever follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a query in progress");

  // the final entry carries the back position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> (position_o == POS_W'(LIST_SIZE - 1)))
    else $error("last flag on the wrong position");

  // an accepted query makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("query accepted but block not busy");

  // found stays the same across one run of results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> (result_valid_o && $stable(found_o)))
    else $error("result run broken or found flag changed");

endmodule

>>> rtl/mtf_ctrl.sv
// controller for the move-to-front list: idle, find pass, emit pass
// depends on mtf_pkg
module mtf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  mtf_pkg::mtf_stat_t stat_i,
  output mtf_pkg::mtf_cmd_t  cmd_o,
  output logic               busy
);
  import mtf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_FIND;
            busy_q  <= 1'b1;
          end
        end
        ST_FIND: begin
          if (stat_i.cnt_last) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (stat_i.cnt_last) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.load      = (state_q == ST_IDLE) && start;
    cmd_o.find_step = (state_q == ST_FIND);
    cmd_o.emit_step = (state_q == ST_EMIT);
  end

  assign busy = busy_q;

endmodule

>>> rtl/mtf_dpath.sv
// datapath for the move-to-front list: order registers, scan counter,
// hit capture and registered result outputs; depends on mtf_pkg
module mtf_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtf_pkg::mtf_cmd_t              cmd_i,
  input  logic [mtf_pkg::QUERY_W-1:0]    query_value_i,
  output mtf_pkg::mtf_stat_t             stat_o,
  output logic                           result_valid_o,
  output logic [mtf_pkg::ENTRY_W-1:0]    entry_value_o,
  output logic [mtf_pkg::POS_W-1:0]      position_o,
  output logic                           found_o,
  output logic                           last_o
);
  import mtf_pkg::*;

  val_t                 order_q [LIST_SIZE];
  idx_t                 cnt_q;
  logic                 cnt_last;
  logic [QUERY_W-1:0]   query_q;
  logic                 hit_q;
  idx_t                 hit_idx_q;
  val_t                 hit_val_q;
  val_t                 prev_q;
  val_t                 cur_val;
  val_t                 new_val;
  logic                 match;

  assign cnt_last = (cnt_q == idx_t'(LIST_SIZE - 1));
  assign stat_o.cnt_last = cnt_last;

  assign cur_val = order_q[cnt_q];
  assign match   = (QUERY_W'(cur_val) == query_q);

  // entries up to the hit slide back by one, the hit value lands in front
  always_comb begin
    new_val = cur_val;
    if (hit_q) begin
      if (cnt_q == '0) begin
        new_val = hit_val_q;
      end else if (cnt_q <= hit_idx_q) begin
        new_val = prev_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hit_q <= 1'b0;
      for (int i = 0; i < LIST_SIZE; i++) begin
        order_q[i] <= val_t'(i + 1);
      end
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit_step;
      if (cmd_i.load) begin
        cnt_q <= '0;
        hit_q <= 1'b0;
      end else if (cmd_i.find_step || cmd_i.emit_step) begin
        cnt_q <= cnt_last ? '0 : cnt_q + idx_t'(1);
        if (cmd_i.find_step && match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (cmd_i.emit_step) begin
          order_q[cnt_q] <= new_val;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      query_q <= query_value_i;
    end
    if (cmd_i.find_step && match && !hit_q) begin
      hit_idx_q <= cnt_q;
      hit_val_q <= cur_val;
    end
    if (cmd_i.emit_step) begin
      prev_q        <= cur_val;
      entry_value_o <= ENTRY_W'(new_val);
      position_o    <= POS_W'(cnt_q);
      found_o       <= hit_q;
      last_o        <= cnt_last;
    end
  end

endmodule
